@@ rtl/assert_macros.svh @@
// Assertion helpers. All checks sample on i_clk and are off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/id3tfe_pkg.sv @@
package id3tfe_pkg;

    localparam logic [31:0] HEADER_BYTES = 32'd10;
    localparam logic [31:0] ID_BYTES     = 32'd4;
    localparam logic [31:0] SIZE_BYTES   = 32'd4;
    localparam logic [31:0] SKIP_BYTES   = 32'd3;
    localparam logic [2:0]  FIELD_COUNT  = 3'd6;
    localparam logic [2:0]  NO_FIELD     = 3'd7;

    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
    localparam logic [31:0] ID_COMM = 32'h434F_4D4D;

    typedef struct packed {
        logic [2:0] field_index;
        logic [7:0] text_byte;
        logic       last_of_field;
        logic       field_empty;
        logic       all_found;
    } t_result;

    function automatic logic [2:0] lookup_id(input logic [31:0] id);
        logic [2:0] idx;
        idx = NO_FIELD;
        if (id == ID_TIT2) idx = 3'd0;
        if (id == ID_TPE1) idx = 3'd1;
        if (id == ID_TALB) idx = 3'd2;
        if (id == ID_TYER) idx = 3'd3;
        if (id == ID_TCON) idx = 3'd4;
        if (id == ID_COMM) idx = 3'd5;
        return idx;
    endfunction

endpackage

@@ rtl/id3_text_frame_extractor.sv @@
// ID3v2.3 text frame extractor.
// Input channel (i_valid/o_ready): one tag byte per beat, with i_new_tag set
// on the first byte of each tag to restart the parse from the tag header.
// Output channel (o_valid/i_ready): one beat per payload byte of a TIT2, TPE1,
// TALB, TYER, TCON or COMM frame, tagged with its field index, plus an empty
// marker beat for a recognized frame whose size is 0 or 1. last_of_field
// flags the end of a field, all_found the end of the sixth recognized field;
// after that, bytes are swallowed until the next new_tag.
// A byte accepted into the input register is parsed as it moves on, and its
// result is then held in the result register, which drives the output.
// Throughput: one byte per cycle while the output is not stalled; the
// per-byte state update is a single pass of compare and 32-bit count logic
// between the input register and the result register.
// Reset: synchronous, active low; both stages empty, parser in header skip.
// Stall: while i_ready is low the result holds; one more byte may wait in
// the input register, then o_ready drops until the result is taken.
`include "assert_macros.svh"

module id3_text_frame_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_tag_byte,
    input  logic       i_new_tag,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_field_index,
    output logic [7:0] o_text_byte,
    output logic       o_last_of_field,
    output logic       o_field_empty,
    output logic       o_all_found
);

    logic                in_valid;
    logic [7:0]          in_byte;
    logic                in_new_tag;
    logic                take;
    logic                out_free;
    logic                res_valid;
    id3tfe_pkg::t_result res;
    id3tfe_pkg::t_result out_res;

    assign take = in_valid && out_free;

    id3tfe_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_tag_byte (i_tag_byte),
        .i_new_tag  (i_new_tag),
        .i_take     (take),
        .o_valid    (in_valid),
        .o_tag_byte (in_byte),
        .o_new_tag  (in_new_tag)
    );

    id3tfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_tag_byte  (in_byte),
        .i_new_tag   (in_new_tag),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    id3tfe_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_field_index   = out_res.field_index;
    assign o_text_byte     = out_res.text_byte;
    assign o_last_of_field = out_res.last_of_field;
    assign o_field_empty   = out_res.field_empty;
    assign o_all_found     = out_res.all_found;

    `ASSERT_IMPL(a_index_known, o_valid, o_field_index < id3tfe_pkg::FIELD_COUNT)
    `ASSERT_IMPL(a_empty_is_last, o_valid && o_field_empty, o_last_of_field)
    `ASSERT_IMPL(a_all_is_last, o_valid && o_all_found, o_last_of_field)
    `ASSERT_NEXT(a_done_quiet, o_valid && i_ready && o_all_found, !o_valid)

endmodule

@@ rtl/id3tfe_in_stage.sv @@
module id3tfe_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_tag_byte,
    input  logic       i_new_tag,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_tag_byte,
    output logic       o_new_tag
);

    logic       r_valid;
    logic [7:0] r_tag_byte;
    logic       r_new_tag;

    assign o_ready    = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_tag_byte = r_tag_byte;
    assign o_new_tag  = r_new_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_tag_byte <= i_tag_byte;
            r_new_tag  <= i_new_tag;
        end
    end

endmodule

@@ rtl/id3tfe_parser.sv @@
module id3tfe_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_tag_byte,
    input  logic                 i_new_tag,
    output logic                 o_res_valid,
    output id3tfe_pkg::t_result  o_res
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_ID      = 3'd1,
        PH_SIZE    = 3'd2,
        PH_SKIP    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase, phase;
    logic [31:0] r_cnt, n_cnt, cnt;
    logic [31:0] r_id, n_id, id;
    logic [31:0] r_len, n_len, len;
    logic [2:0]  r_found, n_found, found;
    logic [2:0]  r_cur, n_cur, cur;
    logic [31:0] cnt_inc, cnt_dec;
    logic [2:0]  found_inc;
    logic        all;

    always_comb begin
        phase = r_phase;
        cnt   = r_cnt;
        id    = r_id;
        len   = r_len;
        found = r_found;
        cur   = r_cur;
        if (i_new_tag) begin
            phase = PH_HEADER;
            cnt   = 32'd0;
            id    = 32'd0;
            len   = 32'd0;
            found = 3'd0;
            cur   = id3tfe_pkg::NO_FIELD;
        end
        n_phase   = phase;
        n_cnt     = cnt;
        n_id      = id;
        n_len     = len;
        n_found   = found;
        n_cur     = cur;
        cnt_inc   = cnt + 32'd1;
        cnt_dec   = cnt - 32'd1;
        found_inc = found + 3'd1;
        all       = (found_inc >= id3tfe_pkg::FIELD_COUNT);
        o_res_valid         = 1'b0;
        o_res.field_index   = cur;
        o_res.text_byte     = i_tag_byte;
        o_res.last_of_field = 1'b0;
        o_res.field_empty   = 1'b0;
        o_res.all_found     = 1'b0;

        case (phase)
            PH_HEADER: begin
                if (cnt_inc >= id3tfe_pkg::HEADER_BYTES) begin
                    n_cnt   = 32'd0;
                    n_phase = PH_ID;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_ID: begin
                n_id = {id[23:0], i_tag_byte};
                if (cnt_inc >= id3tfe_pkg::ID_BYTES) begin
                    n_cnt   = 32'd0;
                    n_cur   = id3tfe_pkg::lookup_id(n_id);
                    n_phase = PH_SIZE;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_SIZE: begin
                n_len = {len[23:0], i_tag_byte};
                if (cnt_inc >= id3tfe_pkg::SIZE_BYTES) begin
                    n_cnt   = 32'd0;
                    n_phase = PH_SKIP;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_SKIP: begin
                if (cnt_inc >= id3tfe_pkg::SKIP_BYTES) begin
                    n_cnt = 32'd0;
                    if (len <= 32'd1) begin
                        n_cur = id3tfe_pkg::NO_FIELD;
                        if (cur < id3tfe_pkg::FIELD_COUNT) begin
                            o_res_valid         = 1'b1;
                            o_res.text_byte     = 8'd0;
                            o_res.last_of_field = 1'b1;
                            o_res.field_empty   = 1'b1;
                            o_res.all_found     = all;
                            n_found             = found_inc;
                            n_phase             = all ? PH_DONE : PH_ID;
                        end else begin
                            n_phase = PH_ID;
                        end
                    end else begin
                        n_cnt   = len - 32'd1;
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_PAYLOAD: begin
                n_cnt = cnt_dec;
                if (cur < id3tfe_pkg::FIELD_COUNT) begin
                    o_res_valid         = 1'b1;
                    o_res.last_of_field = (cnt_dec == 32'd0);
                    if (cnt_dec == 32'd0) begin
                        o_res.all_found = all;
                        n_found         = found_inc;
                        n_cur           = id3tfe_pkg::NO_FIELD;
                        n_phase         = all ? PH_DONE : PH_ID;
                    end
                end else if (cnt_dec == 32'd0) begin
                    n_cur   = id3tfe_pkg::NO_FIELD;
                    n_phase = PH_ID;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cnt   <= 32'd0;
            r_id    <= 32'd0;
            r_len   <= 32'd0;
            r_found <= 3'd0;
            r_cur   <= id3tfe_pkg::NO_FIELD;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_id    <= n_id;
            r_len   <= n_len;
            r_found <= n_found;
            r_cur   <= n_cur;
        end
    end

endmodule

@@ rtl/id3tfe_out_stage.sv @@
module id3tfe_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  id3tfe_pkg::t_result  i_res,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output id3tfe_pkg::t_result  o_res
);

    logic                r_valid;
    id3tfe_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ sim/id3_text_frame_extractor_tb.sv @@
`timescale 1ns / 1ps

module id3_text_frame_extractor_tb;

    localparam int ITEM_TARGET = 1450;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 500;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_SIZE,
        PH_SKIP,
        PH_PAYLOAD,
        PH_DONE
    } t_parse_phase;

    function automatic logic [31:0] text_frame_id(input int idx);
        case (idx)
            0:       return id3tfe_pkg::ID_TIT2;
            1:       return id3tfe_pkg::ID_TPE1;
            2:       return id3tfe_pkg::ID_TALB;
            3:       return id3tfe_pkg::ID_TYER;
            4:       return id3tfe_pkg::ID_TCON;
            default: return id3tfe_pkg::ID_COMM;
        endcase
    endfunction

    class text_frame_scoreboard;
        t_parse_phase         phase;
        logic [31:0]          count;
        logic [31:0]          id_shift;
        logic [31:0]          frame_len;
        logic [2:0]           fields_found;
        logic [2:0]           cur_field;
        id3tfe_pkg::t_result  text_beats_q[$];
        int                   mismatches;
        int                   bytes_taken;
        int                   beats_checked;
        int                   empty_markers;
        int                   tags_completed;
        int                   restarts;
        int                   bytes_ignored;

        function new();
            restart();
        endfunction

        function void restart();
            phase        = PH_HEADER;
            count        = '0;
            id_shift     = '0;
            frame_len    = '0;
            fields_found = '0;
            cur_field    = id3tfe_pkg::NO_FIELD;
        endfunction

        function logic [2:0] match_text_id(input logic [31:0] id);
            for (int i = 0; i < int'(id3tfe_pkg::FIELD_COUNT); i++) begin
                if (text_frame_id(i) == id) begin
                    return 3'(i);
                end
            end
            return id3tfe_pkg::NO_FIELD;
        endfunction

        function logic close_field();
            fields_found = fields_found + 3'd1;
            cur_field    = id3tfe_pkg::NO_FIELD;
            if (fields_found >= id3tfe_pkg::FIELD_COUNT) begin
                phase = PH_DONE;
                tags_completed++;
                return 1'b1;
            end
            phase = PH_ID;
            return 1'b0;
        endfunction

        function void note_byte(input logic [7:0] b, input logic new_tag);
            id3tfe_pkg::t_result r;
            if (new_tag) begin
                restart();
                restarts++;
            end
            bytes_taken++;
            case (phase)
                PH_HEADER: begin
                    count++;
                    if (count >= id3tfe_pkg::HEADER_BYTES) begin
                        count = '0;
                        phase = PH_ID;
                    end
                end
                PH_ID: begin
                    id_shift = {id_shift[23:0], b};
                    count++;
                    if (count >= id3tfe_pkg::ID_BYTES) begin
                        count     = '0;
                        cur_field = match_text_id(id_shift);
                        phase     = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    frame_len = {frame_len[23:0], b};
                    count++;
                    if (count >= id3tfe_pkg::SIZE_BYTES) begin
                        count = '0;
                        phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    count++;
                    if (count >= id3tfe_pkg::SKIP_BYTES) begin
                        count = '0;
                        if (frame_len <= 32'd1) begin
                            if (cur_field < id3tfe_pkg::FIELD_COUNT) begin
                                r.field_index   = cur_field;
                                r.text_byte     = 8'h00;
                                r.last_of_field = 1'b1;
                                r.field_empty   = 1'b1;
                                r.all_found     = close_field();
                                text_beats_q.push_back(r);
                            end else begin
                                cur_field = id3tfe_pkg::NO_FIELD;
                                phase     = PH_ID;
                            end
                        end else begin
                            count = frame_len - 32'd1;
                            phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    count--;
                    if (cur_field < id3tfe_pkg::FIELD_COUNT) begin
                        r.field_index   = cur_field;
                        r.text_byte     = b;
                        r.last_of_field = (count == 32'd0);
                        r.field_empty   = 1'b0;
                        r.all_found     = r.last_of_field ? close_field() : 1'b0;
                        text_beats_q.push_back(r);
                    end else if (count == 32'd0) begin
                        cur_field = id3tfe_pkg::NO_FIELD;
                        phase     = PH_ID;
                    end
                end
                default: begin
                    bytes_ignored++;
                end
            endcase
        endfunction

        function void check_beat(input id3tfe_pkg::t_result got);
            id3tfe_pkg::t_result want;
            logic                bad;
            if (text_beats_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected beat idx=%0d byte=%02h last=%0b empty=%0b all=%0b",
                             $realtime, got.field_index, got.text_byte, got.last_of_field,
                             got.field_empty, got.all_found);
                end
                return;
            end
            want = text_beats_q.pop_front();
            beats_checked++;
            if (want.field_empty) begin
                empty_markers++;
            end
            bad = (got.field_index !== want.field_index) ||
                  (got.text_byte !== want.text_byte) ||
                  (got.last_of_field !== want.last_of_field) ||
                  (got.field_empty !== want.field_empty) ||
                  (got.all_found !== want.all_found);
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: beat %0d expected idx=%0d byte=%02h last=%0b empty=%0b all=%0b",
                             $realtime, beats_checked, want.field_index, want.text_byte,
                             want.last_of_field, want.field_empty, want.all_found);
                    $display("%0t: beat %0d actual   idx=%0d byte=%02h last=%0b empty=%0b all=%0b",
                             $realtime, beats_checked, got.field_index, got.text_byte,
                             got.last_of_field, got.field_empty, got.all_found);
                end
            end
        endfunction

        function int pending();
            return text_beats_q.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_tag_byte;
    logic       i_new_tag;
    logic       o_valid;
    logic       i_ready;
    logic [2:0] o_field_index;
    logic [7:0] o_text_byte;
    logic       o_last_of_field;
    logic       o_field_empty;
    logic       o_all_found;

    text_frame_scoreboard sb = new();
    logic [8:0] tag_stream_q[$];
    int         counted_bytes;
    int         long_holds;
    int         idle_cycles;

    id3_text_frame_extractor u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_tag_byte      (i_tag_byte),
        .i_new_tag       (i_new_tag),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_field_index   (o_field_index),
        .o_text_byte     (o_text_byte),
        .o_last_of_field (o_last_of_field),
        .o_field_empty   (o_field_empty),
        .o_all_found     (o_all_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void push_byte(input logic [7:0] b, input logic new_tag,
                                      input bit counts);
        tag_stream_q.push_back({new_tag, b});
        if (counts) begin
            counted_bytes++;
        end
    endfunction

    function automatic logic [7:0] rand_text();
        return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(32, 126)) : 8'($urandom);
    endfunction

    function automatic logic [31:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'd0;
        if (r < 20) return 32'd1;
        if (r < 85) return 32'($urandom_range(2, 10));
        if (r < 97) return 32'($urandom_range(11, 40));
        return 32'($urandom_range(41, 260));
    endfunction

    function automatic void push_header(input logic new_tag);
        push_byte(rand_text(), new_tag, 1'b1);
        repeat (id3tfe_pkg::HEADER_BYTES - 1) push_byte(8'($urandom), 1'b0, 1'b1);
    endfunction

    // keep < 0: whole frame; fill < 0: random payload
    function automatic void push_frame(input logic [31:0] id, input logic [31:0] size,
                                       input int keep, input int fill);
        longint     total;
        longint     limit;
        logic [7:0] b;
        total = 64'd11 + ((size <= 32'd1) ? 64'd0 : longint'(size) - 64'd1);
        limit = (keep < 0 || keep > total) ? total : longint'(keep);
        for (int k = 0; k < limit; k++) begin
            if (k < 4) b = id[8 * (3 - k) +: 8];
            else if (k < 8) b = size[8 * (7 - k) +: 8];
            else if (k < 11) b = 8'($urandom);
            else b = (fill < 0) ? rand_text() : 8'(fill);
            push_byte(b, 1'b0, 1'b1);
        end
    endfunction

    function automatic logic [31:0] rand_other_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom;
        if (r < 9) return text_frame_id($urandom_range(0, 5)) ^ (32'd1 << $urandom_range(0, 31));
        return 32'd0;
    endfunction

    function automatic void push_tag(input bit broken);
        int          found;
        int          frames;
        int          cut_at;
        int          r;
        logic [31:0] size;
        push_header(1'b1);
        found  = 0;
        frames = 0;
        cut_at = broken ? $urandom_range(0, 7) : -1;
        while (found < int'(id3tfe_pkg::FIELD_COUNT)) begin
            r = $urandom_range(0, 99);
            if (frames == cut_at) begin
                size = ($urandom_range(0, 1) == 0) ? 32'($urandom) : rand_size();
                push_frame((r < 70) ? text_frame_id($urandom_range(0, 5)) : rand_other_id(),
                           size, $urandom_range(0, 30), -1);
                return;
            end
            if (r < 70) begin
                push_frame(text_frame_id($urandom_range(0, 5)), rand_size(), -1, -1);
                found++;
            end else if (r < 93) begin
                push_frame(rand_other_id(), rand_size(), -1, -1);
            end else begin
                push_frame(32'd0, 32'd0, -1, 0);
            end
            frames++;
        end
        repeat ($urandom_range(0, 5)) push_byte(8'($urandom), 1'b0, 1'b0);
    endfunction

    function automatic void push_noise();
        repeat ($urandom_range(1, 24)) begin
            push_byte(8'($urandom), $urandom_range(0, 19) == 0, 1'b1);
        end
    endfunction

    function automatic void build_directed();
        // tag without new_tag right after reset: empty markers, extremes, skipped id
        push_header(1'b0);
        push_frame(id3tfe_pkg::ID_TIT2, 32'd0, -1, -1);
        push_frame(id3tfe_pkg::ID_TPE1, 32'd1, -1, -1);
        push_frame(id3tfe_pkg::ID_TALB, 32'd2, -1, 8'hFF);
        push_frame(32'h5458_5858, 32'd3, -1, -1);
        push_frame(id3tfe_pkg::ID_TYER, 32'd3, -1, 8'h00);
        push_frame(id3tfe_pkg::ID_TCON, 32'd2, -1, 8'h80);
        push_frame(id3tfe_pkg::ID_COMM, 32'd4, -1, -1);
        repeat (3) push_byte(8'hFF, 1'b0, 1'b0);
        // huge size cut short by a restart mid-payload
        push_header(1'b1);
        push_frame(id3tfe_pkg::ID_TIT2, 32'hFFFF_FFFF, 14, -1);
        // restart in the middle of the header
        push_byte(8'h49, 1'b1, 1'b1);
        repeat (4) push_byte(8'h00, 1'b0, 1'b1);
        // padding, repeated ids, sixth field closed by an empty marker
        push_header(1'b1);
        push_frame(32'd0, 32'd0, -1, 0);
        push_frame(id3tfe_pkg::ID_TCON, 32'd0, -1, -1);
        push_frame(id3tfe_pkg::ID_COMM, 32'd1, -1, -1);
        push_frame(id3tfe_pkg::ID_TIT2, 32'd2, -1, -1);
        push_frame(id3tfe_pkg::ID_TIT2, 32'd0, -1, -1);
        push_frame(id3tfe_pkg::ID_TALB, 32'd2, -1, -1);
        push_frame(id3tfe_pkg::ID_TYER, 32'd0, -1, -1);
        push_byte(8'h54, 1'b0, 1'b0);
    endfunction

    task automatic offer_beat(input logic [8:0] item);
        i_valid    <= 1'b1;
        i_tag_byte <= item[7:0];
        i_new_tag  <= item[8];
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(item[7:0], item[8]);
    endtask

    task automatic send_stream();
        int burst;
        int gap;
        int r;
        while (tag_stream_q.size() > 0) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            repeat (burst) begin
                if (tag_stream_q.size() > 0) begin
                    offer_beat(tag_stream_q.pop_front());
                end
            end
            r   = $urandom_range(0, 9);
            gap = (r < 4) ? 0 : (r < 9) ? $urandom_range(1, 6) : $urandom_range(10, 40);
            if (gap > 0 && tag_stream_q.size() > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int                  mode;
        int                  mode_left;
        int                  hold_left;
        id3tfe_pkg::t_result got;
        i_ready   <= 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.field_index   = o_field_index;
                got.text_byte     = o_text_byte;
                got.last_of_field = o_last_of_field;
                got.field_empty   = o_field_empty;
                got.all_found     = o_all_found;
                sb.check_beat(got);
                if (sb.beats_checked == 60 || sb.beats_checked == 260) begin
                    hold_left = HOLD_CYCLES;
                    long_holds++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= (mode_left % 4 == 0);
                    default: i_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int seg_end;
        int r;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_tag_byte  <= 8'h00;
        i_new_tag   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_directed();
        send_stream();
        wait_drained();

        while (counted_bytes < ITEM_TARGET) begin
            seg_end = counted_bytes + $urandom_range(150, 400);
            while (counted_bytes < seg_end && counted_bytes < ITEM_TARGET) begin
                r = $urandom_range(0, 99);
                if (r < 75) push_tag(1'b0);
                else if (r < 88) push_tag(1'b1);
                else push_noise();
            end
            send_stream();
            if ($urandom_range(0, 2) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("covered %0d tag bytes, %0d text beats, %0d empty markers, %0d complete tags",
                 sb.bytes_taken, sb.beats_checked, sb.empty_markers, sb.tags_completed);
        $display("restarts %0d, bytes dropped after sixth field %0d, long receiver holds %0d",
                 sb.restarts, sb.bytes_ignored, long_holds);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/id3tfe_pkg.sv
rtl/id3tfe_in_stage.sv
rtl/id3tfe_parser.sv
rtl/id3tfe_out_stage.sv
rtl/id3_text_frame_extractor.sv
sim/id3_text_frame_extractor_tb.sv
